>>> hw/rtl/cfc_pkg.sv
package cfc_pkg;

   // Default sizes, handed to the top level parameters
   localparam int NUM_VARS_DEF   = 8;
   localparam int NUM_STATES_DEF = 4;
   localparam int KEY_BITS_DEF   = 8;
   localparam int COUNT_BITS_DEF = 16;

   // Widest command fields over the parameter ranges
   localparam int VAR_MAX_BITS = 3;
   localparam int KEY_MAX_BITS = 12;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      KIND_RECORD = 2'd0,
      KIND_READ   = 2'd1,
      KIND_CLEAR  = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_KEY   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_PARENT_MAP   = 2'd0,
      REG_RADIX        = 2'd1,
      REG_STATE_COUNTS = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      OP_INC    = 2'd0,
      OP_READ   = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_REPORT = 2'd3
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [VAR_MAX_BITS-1:0] var_idx;
      logic [KEY_MAX_BITS-1:0] key;
      logic [1:0]              val;
      logic                    last;
      logic                    read_ok;
      status_type              status;
   } cmd_type;

endpackage

>>> hw/rtl/cfc_front.sv
module cfc_front #(
   parameter int NUM_VARS   = cfc_pkg::NUM_VARS_DEF,
   parameter int NUM_STATES = cfc_pkg::NUM_STATES_DEF,
   parameter int KEY_BITS   = cfc_pkg::KEY_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       kind,
   input  logic [15:0]      record_values,
   input  logic [2:0]       read_variable,
   input  logic [7:0]       read_key,
   input  logic [63:0]      parent_map,
   input  logic [2:0]       radix,
   input  logic [15:0]      state_counts,
   input  logic             clearing,
   input  logic             q_full,
   output logic             q_push,
   output cfc_pkg::cmd_type q_cmd
);

   localparam int VAR_W = $clog2(NUM_VARS);
   localparam logic [VAR_W-1:0] LAST_VAR = VAR_W'(NUM_VARS - 1);
   localparam int PROD_W = KEY_BITS + 3;

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_KEYS = 4'b0010,
      F_PUSH = 4'b0100,
      F_ONE  = 4'b1000
   } fstate_type;

   fstate_type       state_ff, state_in;
   logic [15:0]      rec_ff, rec_in;
   logic [VAR_W-1:0] var_ff, var_in;
   cfc_pkg::cmd_type one_ff, one_in;
   logic [KEY_BITS-1:0] keys_ff [NUM_VARS];
   logic [KEY_BITS-1:0] keys_in [NUM_VARS];
   logic [KEY_BITS-1:0] keys_step [NUM_VARS];
   logic [NUM_VARS-1:0] big_ff, big_in, big_step;

   logic             range_err;
   logic [PROD_W-1:0] prod;

   // value of some variable above its state count, or not below NUM_STATES
   always_comb begin
      range_err = 1'b0;
      for (int v = 0; v < NUM_VARS; v++) begin
         if (record_values[2*v +: 2] > state_counts[2*v +: 2] ||
             {1'b0, record_values[2*v +: 2]} >= 3'(NUM_STATES)) begin
            range_err = 1'b1;
         end
      end
   end

   // one Horner step per cycle for every variable at once; var_ff walks the
   // parent index from the top down. big marks a key past the key space
   // (radix 0 drops everything above the lowest parent)
   always_comb begin
      prod = '0;
      for (int v = 0; v < NUM_VARS; v++) begin
         keys_step[v] = keys_ff[v];
         big_step[v]  = big_ff[v];
         if (parent_map[int'(var_ff)*8 + v]) begin
            prod = PROD_W'(keys_ff[v]) * PROD_W'(radix) +
                   PROD_W'(rec_ff[2*var_ff +: 2]);
            big_step[v]  = (big_ff[v] && radix != 3'd0) ||
                           (prod[PROD_W-1:KEY_BITS] != '0);
            keys_step[v] = prod[KEY_BITS-1:0];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      rec_in   = rec_ff;
      var_in   = var_ff;
      big_in   = big_ff;
      one_in   = one_ff;
      for (int v = 0; v < NUM_VARS; v++) begin
         keys_in[v] = keys_ff[v];
      end
      q_push   = 1'b0;
      q_cmd    = one_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_valid && !clearing) begin
               one_in = cfc_pkg::cmd_type'(0);
               unique case (cfc_pkg::kind_type'(kind))
                  cfc_pkg::KIND_RECORD: begin
                     if (range_err) begin
                        one_in.op     = cfc_pkg::OP_REPORT;
                        one_in.status = cfc_pkg::ST_RANGE;
                        state_in      = F_ONE;
                     end else begin
                        rec_in   = record_values;
                        var_in   = LAST_VAR;
                        big_in   = '0;
                        for (int v = 0; v < NUM_VARS; v++) begin
                           keys_in[v] = '0;
                        end
                        state_in = F_KEYS;
                     end
                  end
                  cfc_pkg::KIND_READ: begin
                     one_in.op      = cfc_pkg::OP_READ;
                     one_in.var_idx = read_variable;
                     one_in.key     = cfc_pkg::KEY_MAX_BITS'(read_key);
                     one_in.read_ok = (32'(read_variable) < NUM_VARS) &&
                                      ((32'(read_key) >> KEY_BITS) == 0);
                     state_in       = F_ONE;
                  end
                  cfc_pkg::KIND_CLEAR: begin
                     one_in.op = cfc_pkg::OP_CLEAR;
                     state_in  = F_ONE;
                  end
                  cfc_pkg::KIND_NONE: begin
                     one_in.op     = cfc_pkg::OP_REPORT;
                     one_in.status = cfc_pkg::ST_OK;
                     state_in      = F_ONE;
                  end
                  default: ;
               endcase
            end
         end
         F_KEYS: begin
            big_in = big_step;
            for (int v = 0; v < NUM_VARS; v++) begin
               keys_in[v] = keys_step[v];
            end
            if (var_ff == '0) begin
               if (|big_step) begin
                  one_in        = cfc_pkg::cmd_type'(0);
                  one_in.op     = cfc_pkg::OP_REPORT;
                  one_in.status = cfc_pkg::ST_KEY;
                  state_in      = F_ONE;
               end else begin
                  state_in = F_PUSH;
               end
            end else begin
               var_in = var_ff - 1'b1;
            end
         end
         F_PUSH: begin
            q_cmd         = cfc_pkg::cmd_type'(0);
            q_cmd.op      = cfc_pkg::OP_INC;
            q_cmd.var_idx = cfc_pkg::VAR_MAX_BITS'(var_ff);
            q_cmd.key     = cfc_pkg::KEY_MAX_BITS'(keys_ff[var_ff]);
            q_cmd.val     = rec_ff[2*var_ff +: 2];
            q_cmd.last    = (var_ff == LAST_VAR);
            q_push        = !q_full;
            if (!q_full) begin
               if (var_ff == LAST_VAR) begin
                  state_in = F_IDLE;
               end else begin
                  var_in = var_ff + 1'b1;
               end
            end
         end
         F_ONE: begin
            q_push = !q_full;
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   assign req_stall = (state_ff != F_IDLE) || clearing;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
      var_ff <= var_in;
      big_ff <= big_in;
      one_ff <= one_in;
      for (int v = 0; v < NUM_VARS; v++) begin
         keys_ff[v] <= keys_in[v];
      end
   end

endmodule

>>> hw/rtl/cfc_queue.sv
module cfc_queue #(
   parameter int DEPTH = cfc_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cfc_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output cfc_pkg::cmd_type head,
   output logic             not_empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

   cfc_pkg::cmd_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;

   assign full      = (count_ff == (PTR_W+1)'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> hw/rtl/cfc_back.sv
module cfc_back #(
   parameter int NUM_VARS   = cfc_pkg::NUM_VARS_DEF,
   parameter int NUM_STATES = cfc_pkg::NUM_STATES_DEF,
   parameter int KEY_BITS   = cfc_pkg::KEY_BITS_DEF,
   parameter int COUNT_BITS = cfc_pkg::COUNT_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  cfc_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             clearing,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_count_state0,
   output logic [15:0]      rsp_count_state1,
   output logic [15:0]      rsp_count_state2,
   output logic [15:0]      rsp_count_state3,
   output logic             rsp_entry_present
);

   localparam int VAR_W    = $clog2(NUM_VARS);
   localparam int ROW_W    = VAR_W + KEY_BITS;
   localparam int ROWS     = NUM_VARS << KEY_BITS;
   localparam int ROW_BITS = NUM_STATES * COUNT_BITS;
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

   typedef enum logic [1:0] {
      B_RUN   = 2'b01,
      B_CLEAR = 2'b10
   } bstate_type;

   // one row per (variable, key): all state counters side by side
   logic [ROW_BITS-1:0] mem [ROWS];
   logic [ROW_BITS-1:0] rdata_ff;
   logic [ROW_BITS-1:0] new_row;
   logic                mem_we;
   logic [ROW_W-1:0]    mem_waddr;
   logic [ROW_BITS-1:0] mem_wdata;
   logic [ROW_W-1:0]    cmd_row;

   bstate_type       state_ff, state_in;
   logic [ROW_W-1:0] sweep_ff, sweep_in;
   logic             sweep_rsp_ff, sweep_rsp_in;

   logic             s1_valid_ff;
   cfc_pkg::cmd_type s1_cmd_ff;
   logic [ROW_W-1:0] s1_row_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [15:0]      cnt_ff [4];
   logic [15:0]      cnt_in [4];
   logic             present_ff, present_in;

   logic             cmd_rsp, cmd_quiet, s1_rsp, s1_clear, load_rsp;
   logic [31:0]      wide;

   assign cmd_row = {cmd.var_idx[VAR_W-1:0], cmd.key[KEY_BITS-1:0]};

   // ops that end in a result, and ops that must see no write in flight
   assign cmd_rsp   = (cmd.op != cfc_pkg::OP_INC) || cmd.last;
   assign cmd_quiet = (cmd.op == cfc_pkg::OP_READ) || (cmd.op == cfc_pkg::OP_CLEAR);
   assign s1_rsp    = s1_valid_ff && ((s1_cmd_ff.op != cfc_pkg::OP_INC) || s1_cmd_ff.last);
   assign s1_clear  = s1_valid_ff && (s1_cmd_ff.op == cfc_pkg::OP_CLEAR);

   assign cmd_pop = cmd_valid && (state_ff == B_RUN) && !s1_clear &&
                    (!cmd_rsp || (!rsp_valid_ff && !s1_rsp)) &&
                    (!cmd_quiet || !s1_valid_ff);

   assign clearing = (state_ff == B_CLEAR) && !sweep_rsp_ff;

   // saturating increment of the addressed state
   always_comb begin
      new_row = rdata_ff;
      for (int s = 0; s < NUM_STATES; s++) begin
         if (2'(s) == s1_cmd_ff.val && rdata_ff[s*COUNT_BITS +: COUNT_BITS] != '1) begin
            new_row[s*COUNT_BITS +: COUNT_BITS] =
               rdata_ff[s*COUNT_BITS +: COUNT_BITS] + 1'b1;
         end
      end
   end

   always_comb begin
      if (state_ff == B_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = sweep_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = s1_valid_ff && (s1_cmd_ff.op == cfc_pkg::OP_INC);
         mem_waddr = s1_row_ff;
         mem_wdata = new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd_pop) begin
         rdata_ff <= mem[cmd_row];
      end
   end

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      sweep_rsp_in = sweep_rsp_ff;
      load_rsp     = s1_rsp && !s1_clear;
      unique case (state_ff)
         B_RUN: begin
            if (s1_clear) begin
               state_in     = B_CLEAR;
               sweep_in     = '0;
               sweep_rsp_in = 1'b1;
            end
         end
         B_CLEAR: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == LAST_ROW) begin
               state_in = B_RUN;
               load_rsp = sweep_rsp_ff;
            end
         end
         default: state_in = B_RUN;
      endcase
   end

   always_comb begin
      rsp_status_in = rsp_status_ff;
      present_in    = present_ff;
      wide          = '0;
      for (int s = 0; s < 4; s++) begin
         cnt_in[s] = cnt_ff[s];
      end
      if (load_rsp) begin
         rsp_status_in = cfc_pkg::ST_OK;
         present_in    = 1'b0;
         for (int s = 0; s < 4; s++) begin
            cnt_in[s] = '0;
         end
         if (state_ff == B_RUN && s1_cmd_ff.op == cfc_pkg::OP_REPORT) begin
            rsp_status_in = s1_cmd_ff.status;
         end
         if (state_ff == B_RUN && s1_cmd_ff.op == cfc_pkg::OP_READ && s1_cmd_ff.read_ok) begin
            for (int s = 0; s < NUM_STATES; s++) begin
               wide      = 32'(rdata_ff[s*COUNT_BITS +: COUNT_BITS]);
               cnt_in[s] = (wide[31:16] != '0) ? 16'hFFFF : wide[15:0];
               if (wide != '0) begin
                  present_in = 1'b1;
               end
            end
         end
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         sweep_ff     <= '0;
         sweep_rsp_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         sweep_rsp_ff <= sweep_rsp_in;
         s1_valid_ff  <= cmd_pop;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         s1_cmd_ff <= cmd;
         s1_row_ff <= cmd_row;
      end
      rsp_status_ff <= rsp_status_in;
      present_ff    <= present_in;
      for (int s = 0; s < 4; s++) begin
         cnt_ff[s] <= cnt_in[s];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_count_state0  = cnt_ff[0];
   assign rsp_count_state1  = cnt_ff[1];
   assign rsp_count_state2  = cnt_ff[2];
   assign rsp_count_state3  = cnt_ff[3];
   assign rsp_entry_present = present_ff;

endmodule

>>> hw/rtl/conditional_frequency_counter_top.sv
// Conditional frequency counter. Each req word is a training record, a read of
// the counts of one (variable, parent key), or a clear; each gives exactly one
// rsp word, in order. For a record the front builds the parent keys of all
// variables side by side, one parent index per cycle from the highest down
// (range is checked on entry), then hands one increment per variable to the
// back. A record whose key is too large gives a key error word instead. The
// back does one read-modify-write per cycle on a count store with a read and
// a write port, unless a result word is held or a read or clear waits for a
// write in flight, so it keeps pace with the front. Reads, clears and other
// kinds pass the front as a single command. After reset, and on every clear,
// the back sweeps all NUM_VARS*2^KEY_BITS rows of the store (2048 at defaults)
// one row per cycle; the rsp word of a clear comes at the end of its sweep.
// req_stall stays high during the sweep after reset. The user must write
// configuration only while the block is idle; the block does not enforce it.
module conditional_frequency_counter_top #(
   parameter int NUM_VARS   = cfc_pkg::NUM_VARS_DEF,
   parameter int NUM_STATES = cfc_pkg::NUM_STATES_DEF,
   parameter int KEY_BITS   = cfc_pkg::KEY_BITS_DEF,
   parameter int COUNT_BITS = cfc_pkg::COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_record_values,
   input  logic [2:0]  req_read_variable,
   input  logic [7:0]  req_read_key,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_count_state0,
   output logic [15:0] rsp_count_state1,
   output logic [15:0] rsp_count_state2,
   output logic [15:0] rsp_count_state3,
   output logic        rsp_entry_present,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data
);

   // configuration registers
   logic [63:0] parent_map_ff;
   logic [2:0]  radix_ff;
   logic [15:0] state_counts_ff;

   // front -> queue -> back
   logic             q_push, q_full, q_pop, q_not_empty;
   cfc_pkg::cmd_type q_in_cmd, q_head;
   logic             clearing;

   always_ff @(posedge clock) begin
      if (reset) begin
         parent_map_ff   <= '0;
         radix_ff        <= 3'd4;
         state_counts_ff <= 16'hFFFF;
      end else if (csr_write_enable) begin
         unique case (cfc_pkg::reg_index_type'(csr_index))
            cfc_pkg::REG_PARENT_MAP:   parent_map_ff   <= csr_write_data;
            cfc_pkg::REG_RADIX:        radix_ff        <= csr_write_data[2:0];
            cfc_pkg::REG_STATE_COUNTS: state_counts_ff <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   // front: checks records, builds keys, turns items into commands
   cfc_front #(
      .NUM_VARS   (NUM_VARS),
      .NUM_STATES (NUM_STATES),
      .KEY_BITS   (KEY_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .kind          (req_kind),
      .record_values (req_record_values),
      .read_variable (req_read_variable),
      .read_key      (req_read_key),
      .parent_map    (parent_map_ff),
      .radix         (radix_ff),
      .state_counts  (state_counts_ff),
      .clearing      (clearing),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (q_in_cmd)
   );

   // short command queue so front and back stall independently
   cfc_queue #(
      .DEPTH (cfc_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_in_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .not_empty (q_not_empty)
   );

   // back: count store, increments, reads, clear sweeps, result register
   cfc_back #(
      .NUM_VARS   (NUM_VARS),
      .NUM_STATES (NUM_STATES),
      .KEY_BITS   (KEY_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (q_not_empty),
      .cmd               (q_head),
      .cmd_pop           (q_pop),
      .clearing          (clearing),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_count_state0  (rsp_count_state0),
      .rsp_count_state1  (rsp_count_state1),
      .rsp_count_state2  (rsp_count_state2),
      .rsp_count_state3  (rsp_count_state3),
      .rsp_entry_present (rsp_entry_present)
   );

endmodule

>>> hw/rtl/cfc_checker.sv
module cfc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_kind,
   input logic [15:0] req_record_values,
   input logic [2:0]  req_read_variable,
   input logic [7:0]  req_read_key,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_count_state0,
   input logic [15:0] rsp_count_state1,
   input logic [15:0] rsp_count_state2,
   input logic [15:0] rsp_count_state3,
   input logic        rsp_entry_present,
   input logic        csr_write_enable,
   input logic [1:0]  csr_index,
   input logic [63:0] csr_write_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   a_err_no_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != cfc_pkg::ST_OK |->
         rsp_count_state0 == 16'd0 && rsp_count_state1 == 16'd0 &&
         rsp_count_state2 == 16'd0 && rsp_count_state3 == 16'd0 && !rsp_entry_present)
      else $error("error word carries counts");

   a_present: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_present ==
         ((rsp_count_state0 | rsp_count_state1 | rsp_count_state2 | rsp_count_state3) != 16'd0))
      else $error("entry_present disagrees with counts");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= 2'(cfc_pkg::ST_KEY))
      else $error("undefined status code");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp word right after reset");

endmodule

bind conditional_frequency_counter_top cfc_checker u_cfc_checker (.*);
